### hw/rtl/udp_ipv6_frame_builder_core_defines.svh
// Assertion macros shared by the frame builder RTL.
`ifndef UDP_IPV6_FRAME_BUILDER_CORE_DEFINES_SVH
`define UDP_IPV6_FRAME_BUILDER_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising edge outside reset.
`define UFB_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame builder check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define UFB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame builder check failed");

`else

`define UFB_ASSERT_NOW(lbl, ante, cons)
`define UFB_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### hw/rtl/ufb_pkg.sv
// Types and fixed header constants of the UDP/IPv6 frame builder.
`timescale 1ns / 1ps
`default_nettype none

package ufb_pkg;

   // configuration register index
   typedef logic [2:0] reg_index_type;

   localparam reg_index_type REG_SOURCE_MAC      = 3'd0;
   localparam reg_index_type REG_DEST_MAC        = 3'd1;
   localparam reg_index_type REG_SOURCE_IP_UPPER = 3'd2;
   localparam reg_index_type REG_SOURCE_IP_LOWER = 3'd3;
   localparam reg_index_type REG_SOURCE_PORT     = 3'd4;
   localparam reg_index_type REG_HOP_LIMIT       = 3'd5;
   localparam reg_index_type REG_CHECK_WORD      = 3'd6;

   // register reset values
   localparam logic [47:0] RST_SOURCE_MAC = 48'hA036_9F45_D874;
   localparam logic [47:0] RST_DEST_MAC   = 48'hFFFF_FFFF_FFFF;
   localparam logic [7:0]  RST_HOP_LIMIT  = 8'hFF;
   localparam logic [15:0] RST_CHECK_WORD = 16'hAAFF;

   // header layout
   localparam logic [5:0]  HEADER_BYTES   = 6'd62;
   localparam logic [15:0] MAX_PAYLOAD    = 16'd65527;
   localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;
   localparam logic [15:0] ETHERTYPE_V6   = 16'h86DD;
   localparam logic [31:0] IP_VER_FLOW    = 32'h6000_0000;
   localparam logic [7:0]  NEXT_HDR_UDP   = 8'd17;

   // widths of the stream payloads
   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 40;

   // one result item before packing
   typedef struct packed {
      logic [7:0]  frame_byte;
      logic        frame_last;
      logic [16:0] frame_size;
      logic [7:0]  ring_slot;
      logic        sequence_error;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/udp_ipv6_frame_builder_core.sv
// UDP/IPv6/Ethernet frame builder: header burst then payload bytes.
//
//  channel  dir  data                                            user             last
//  req_     in   dest_ip_upper dest_ip_lower dest_port plen byte starts_packet    -
//  rsp_     out  frame_byte frame_size ring_slot                 sequence_error   frame_last
//  csr_     in   write enable, 3-bit index, 64-bit data          -                -
//
//  A first item (starts_packet set) gives 63 items out: 62 header bytes from the header byte
//  counter, then its payload byte. Every other item gives one item out, so payload flows at
//  one byte per cycle while rsp_tready stays high.
//  Reset is synchronous, active high; it clears the packet state, the ring slot and both
//  valid flags, and loads the register defaults.
//  rsp_tready low holds the output register and pauses the header counter; the input is
//  taken in the same cycle that the held item gives its final output.
`timescale 1ns / 1ps
`default_nettype none

`include "udp_ipv6_frame_builder_core_defines.svh"

module udp_ipv6_frame_builder_core #(
   parameter int RING_FRAMES = 256
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request: tdata = dest_ip_upper, dest_ip_lower, dest_port, payload_length,
   //          payload_byte (lowest bits first); tuser = starts_packet
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [ufb_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                              req_tuser,
   // response: tdata = frame_byte, frame size, ring_slot, 7 zero bits
   //           (lowest bits first); tuser = sequence_error; tlast = frame_last
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [ufb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output      logic                              rsp_tuser,
   output      logic                              rsp_tlast,
   // configuration write port
   input  wire logic                              csr_we,
   input  wire ufb_pkg::reg_index_type            csr_addr,
   input  wire logic [63:0]                       csr_wdata
);
   import ufb_pkg::*;

   localparam int SLOT_W = $clog2(RING_FRAMES);

   // configuration registers
   logic [47:0] source_mac_ff;
   logic [47:0] dest_mac_ff;
   logic [63:0] source_ip_upper_ff;
   logic [63:0] source_ip_lower_ff;
   logic [15:0] source_port_ff;
   logic [7:0]  hop_limit_ff;
   logic [15:0] check_word_ff;

   // held input item
   logic                  hold_valid_ff, hold_valid_in;
   logic [REQ_DATA_W-1:0] hold_data_ff;
   logic                  hold_starts_ff;
   logic [5:0]            idx_ff, idx_in;

   // packet state
   logic              packet_open_ff, packet_open_in;
   logic [15:0]       rem_ff, rem_in;
   logic [16:0]       cur_len_ff, cur_len_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // datapath
   logic              accept, produce, out_free, item_done;
   logic              in_header, stray;
   logic [15:0]       plen_raw, plen_sat, ulen, rem_base, rem_next;
   logic [16:0]       flen_new, flen_sel;
   logic [495:0]      hdr_vec;
   logic [5:0]        hdr_sel;
   logic [7:0]        hdr_byte;
   logic [SLOT_W+7:0] slot_ext;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         source_mac_ff      <= RST_SOURCE_MAC;
         dest_mac_ff        <= RST_DEST_MAC;
         source_ip_upper_ff <= '0;
         source_ip_lower_ff <= '0;
         source_port_ff     <= '0;
         hop_limit_ff       <= RST_HOP_LIMIT;
         check_word_ff      <= RST_CHECK_WORD;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_SOURCE_MAC:      source_mac_ff      <= csr_wdata[47:0];
            REG_DEST_MAC:        dest_mac_ff        <= csr_wdata[47:0];
            REG_SOURCE_IP_UPPER: source_ip_upper_ff <= csr_wdata;
            REG_SOURCE_IP_LOWER: source_ip_lower_ff <= csr_wdata;
            REG_SOURCE_PORT:     source_port_ff     <= csr_wdata[15:0];
            REG_HOP_LIMIT:       hop_limit_ff       <= csr_wdata[7:0];
            REG_CHECK_WORD:      check_word_ff      <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // length handling and header image
   always_comb begin
      plen_raw = hold_data_ff[159:144];
      if (plen_raw == 16'd0) begin
         plen_sat = 16'd1;
      end else if (plen_raw > MAX_PAYLOAD) begin
         plen_sat = MAX_PAYLOAD;
      end else begin
         plen_sat = plen_raw;
      end
      ulen     = UDP_HDR_BYTES + plen_sat;
      flen_new = {11'd0, HEADER_BYTES} + {1'b0, plen_sat};
      hdr_vec  = {dest_mac_ff, source_mac_ff, ETHERTYPE_V6, IP_VER_FLOW, ulen,
                  NEXT_HDR_UDP, hop_limit_ff, source_ip_upper_ff, source_ip_lower_ff,
                  hold_data_ff[63:0], hold_data_ff[127:64], source_port_ff,
                  hold_data_ff[143:128], ulen, check_word_ff};
      hdr_sel  = HEADER_BYTES - 6'd1 - idx_ff;
      hdr_byte = hdr_vec[{hdr_sel, 3'b000} +: 8];
   end

   // handshake and next result
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_tready;
      produce   = hold_valid_ff && out_free;
      in_header = hold_starts_ff && (idx_ff != HEADER_BYTES);
      stray     = !hold_starts_ff && !packet_open_ff;
      item_done = produce && !in_header;
      req_tready = !hold_valid_ff || item_done;
      accept    = req_tvalid && req_tready;

      rem_base = hold_starts_ff ? plen_sat : rem_ff;
      rem_next = rem_base - 16'd1;
      flen_sel = hold_starts_ff ? flen_new : cur_len_ff;
      slot_ext = (SLOT_W + 8)'(slot_ff);

      rsp_in.ring_slot = slot_ext[7:0];
      if (in_header) begin
         rsp_in.frame_byte     = hdr_byte;
         rsp_in.frame_last     = 1'b0;
         rsp_in.frame_size     = '0;
         rsp_in.sequence_error = (idx_ff == 6'd0) && packet_open_ff;
      end else if (stray) begin
         rsp_in.frame_byte     = '0;
         rsp_in.frame_last     = 1'b0;
         rsp_in.frame_size     = '0;
         rsp_in.sequence_error = 1'b1;
      end else begin
         rsp_in.frame_byte     = hold_data_ff[167:160];
         rsp_in.frame_last     = (rem_next == 16'd0);
         rsp_in.frame_size     = (rem_next == 16'd0) ? flen_sel : 17'd0;
         rsp_in.sequence_error = 1'b0;
      end
   end

   // next control state
   always_comb begin
      hold_valid_in  = hold_valid_ff;
      idx_in         = idx_ff;
      packet_open_in = packet_open_ff;
      rem_in         = rem_ff;
      cur_len_in     = cur_len_ff;
      slot_in        = slot_ff;
      rsp_valid_in   = rsp_valid_ff;

      if (produce && in_header) begin
         idx_in = idx_ff + 6'd1;
      end
      if (item_done) begin
         hold_valid_in = 1'b0;
      end
      if (accept) begin
         hold_valid_in = 1'b1;
         idx_in        = '0;
      end

      // packet bookkeeping on the payload byte of a valid item
      if (item_done && !stray) begin
         rem_in         = rem_next;
         packet_open_in = (rem_next != 16'd0);
         if (hold_starts_ff) begin
            cur_len_in = flen_new;
         end
         if (rem_next == 16'd0) begin
            slot_in = (slot_ff == SLOT_W'(RING_FRAMES - 1)) ? '0 : slot_ff + 1'b1;
         end
      end

      if (produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff  <= 1'b0;
         idx_ff         <= '0;
         packet_open_ff <= 1'b0;
         rem_ff         <= '0;
         cur_len_ff     <= '0;
         slot_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         hold_valid_ff  <= hold_valid_in;
         idx_ff         <= idx_in;
         packet_open_ff <= packet_open_in;
         rem_ff         <= rem_in;
         cur_len_ff     <= cur_len_in;
         slot_ff        <= slot_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         hold_data_ff   <= req_tdata;
         hold_starts_ff <= req_tuser;
      end
      if (produce) begin
         rsp_ff <= rsp_in;
      end
   end

   // output packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.ring_slot, rsp_ff.frame_size, rsp_ff.frame_byte};
   assign rsp_tuser  = rsp_ff.sequence_error;
   assign rsp_tlast  = rsp_ff.frame_last;

   // checks
   `UFB_ASSERT_NOW(a_open_has_bytes, 1'b1, packet_open_ff == (rem_ff != 16'd0))
   `UFB_ASSERT_NOW(a_data_no_header, hold_valid_ff && !hold_starts_ff, idx_ff == 6'd0)
   `UFB_ASSERT_NOW(a_last_length, rsp_valid_ff && rsp_ff.frame_last,
                   rsp_ff.frame_size >= 17'd63)
   `UFB_ASSERT_NOW(a_error_not_last, rsp_valid_ff && rsp_ff.sequence_error,
                   !rsp_ff.frame_last && (rsp_ff.frame_size == 17'd0))
   `UFB_ASSERT_NEXT(a_header_steps, produce && in_header && !accept,
                    idx_ff == $past(idx_ff) + 6'd1)

endmodule

`default_nettype wire

### tb/frame_byte_checker.sv
// Frame byte checker: mirrors the frame builder and compares every output item.
`timescale 1ns / 1ps

module frame_byte_checker #(
   parameter int RING_FRAMES = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [ufb_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [ufb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tuser,
   input  logic                           rsp_tlast,
   input  logic                           csr_we,
   input  ufb_pkg::reg_index_type         csr_addr,
   input  logic [63:0]                    csr_wdata,
   output int                             mismatches,
   output int                             bytes_pending,
   output int                             bytes_checked
);
   import ufb_pkg::*;

   // register copies
   logic [47:0] src_mac;
   logic [47:0] dst_mac;
   logic [63:0] src_ip_hi;
   logic [63:0] src_ip_lo;
   logic [15:0] udp_sport;
   logic [7:0]  hops;
   logic [15:0] csum_word;

   // packet state
   logic        pkt_open;
   logic [15:0] bytes_left;
   logic [16:0] frame_len;
   int          slot_count;

   rsp_type frame_bytes_due[$];

   initial begin
      mismatches    = 0;
      bytes_pending = 0;
      bytes_checked = 0;
   end

   function automatic void queue_byte(input logic [7:0] b, input logic last,
                                      input logic [16:0] flen, input logic err);
      rsp_type r;
      r.frame_byte     = b;
      r.frame_last     = last;
      r.frame_size     = flen;
      r.ring_slot      = slot_count[7:0];
      r.sequence_error = err;
      frame_bytes_due.push_back(r);
   endfunction

   // header burst on a first item, then the payload byte
   task automatic predict_frame_bytes(input logic starts, input logic [REQ_DATA_W-1:0] d);
      logic [7:0]  hdr [0:61];
      logic [63:0] dst_hi;
      logic [63:0] dst_lo;
      logic [15:0] udp_dport;
      logic [15:0] n;
      logic [15:0] udp_len;
      logic [7:0]  pbyte;
      logic        cut;
      dst_hi    = d[63:0];
      dst_lo    = d[127:64];
      udp_dport = d[143:128];
      n         = d[159:144];
      pbyte     = d[167:160];
      if (starts) begin
         cut = pkt_open;
         if (n == 16'd0) n = 16'd1;
         if (n > MAX_PAYLOAD) n = MAX_PAYLOAD;
         udp_len = UDP_HDR_BYTES + n;
         for (int i = 0; i < 6; i++) begin
            hdr[i]     = dst_mac[47 - 8*i -: 8];
            hdr[6 + i] = src_mac[47 - 8*i -: 8];
         end
         hdr[12] = ETHERTYPE_V6[15:8];
         hdr[13] = ETHERTYPE_V6[7:0];
         for (int i = 0; i < 4; i++) hdr[14 + i] = IP_VER_FLOW[31 - 8*i -: 8];
         hdr[18] = udp_len[15:8];
         hdr[19] = udp_len[7:0];
         hdr[20] = NEXT_HDR_UDP;
         hdr[21] = hops;
         for (int i = 0; i < 8; i++) begin
            hdr[22 + i] = src_ip_hi[63 - 8*i -: 8];
            hdr[30 + i] = src_ip_lo[63 - 8*i -: 8];
            hdr[38 + i] = dst_hi[63 - 8*i -: 8];
            hdr[46 + i] = dst_lo[63 - 8*i -: 8];
         end
         hdr[54] = udp_sport[15:8];
         hdr[55] = udp_sport[7:0];
         hdr[56] = udp_dport[15:8];
         hdr[57] = udp_dport[7:0];
         hdr[58] = udp_len[15:8];
         hdr[59] = udp_len[7:0];
         hdr[60] = csum_word[15:8];
         hdr[61] = csum_word[7:0];
         // only the first header byte flags an abandoned packet
         for (int i = 0; i < 62; i++) queue_byte(hdr[i], 1'b0, 17'd0, (i == 0) ? cut : 1'b0);
         pkt_open   = 1'b1;
         bytes_left = n;
         frame_len  = 17'(HEADER_BYTES) + 17'(n);
      end else if (!pkt_open) begin
         // stray byte: dropped, flagged
         queue_byte(8'h00, 1'b0, 17'd0, 1'b1);
         return;
      end
      bytes_left = bytes_left - 16'd1;
      if (bytes_left == 16'd0) begin
         queue_byte(pbyte, 1'b1, frame_len, 1'b0);
         pkt_open   = 1'b0;
         slot_count = (slot_count + 1) % RING_FRAMES;
      end else begin
         queue_byte(pbyte, 1'b0, 17'd0, 1'b0);
      end
   endtask

   function automatic void check_field(input string name, input logic [16:0] want,
                                       input logic [16:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         src_mac    = RST_SOURCE_MAC;
         dst_mac    = RST_DEST_MAC;
         src_ip_hi  = '0;
         src_ip_lo  = '0;
         udp_sport  = '0;
         hops       = RST_HOP_LIMIT;
         csum_word  = RST_CHECK_WORD;
         pkt_open   = 1'b0;
         bytes_left = '0;
         frame_len  = '0;
         slot_count = 0;
         frame_bytes_due.delete();
      end else begin
         // compare the output item against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            bytes_checked++;
            if (frame_bytes_due.size() == 0) begin
               $display("%0t ns: unexpected output item, expected none actual %h", $time,
                        {rsp_tlast, rsp_tuser, rsp_tdata});
               mismatches++;
            end else begin
               want = frame_bytes_due.pop_front();
               check_field("frame_byte", 17'(want.frame_byte), 17'(rsp_tdata[7:0]));
               check_field("frame_size", want.frame_size, rsp_tdata[24:8]);
               check_field("ring_slot", 17'(want.ring_slot), 17'(rsp_tdata[32:25]));
               check_field("pad bits", 17'd0, 17'(rsp_tdata[39:33]));
               check_field("frame_last", 17'(want.frame_last), 17'(rsp_tlast));
               check_field("sequence_error", 17'(want.sequence_error), 17'(rsp_tuser));
            end
         end
         if (csr_we) begin
            case (csr_addr)
               REG_SOURCE_MAC:      src_mac   = csr_wdata[47:0];
               REG_DEST_MAC:        dst_mac   = csr_wdata[47:0];
               REG_SOURCE_IP_UPPER: src_ip_hi = csr_wdata;
               REG_SOURCE_IP_LOWER: src_ip_lo = csr_wdata;
               REG_SOURCE_PORT:     udp_sport = csr_wdata[15:0];
               REG_HOP_LIMIT:       hops      = csr_wdata[7:0];
               REG_CHECK_WORD:      csum_word = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_frame_bytes(req_tuser, req_tdata);
      end
      bytes_pending = frame_bytes_due.size();
   end

endmodule

### tb/tb_top.sv
// Top of the frame builder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
   import ufb_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // dest_ip_upper, dest_ip_lower, dest_port,
                                       // payload_length, payload_byte (low bits first)
   logic                  req_tuser;   // starts_packet
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // frame_byte, frame size, ring_slot, zero pad
   logic                  rsp_tuser;   // sequence_error
   logic                  rsp_tlast;   // frame_last
   logic                  csr_we;
   reg_index_type         csr_addr;
   logic [63:0]           csr_wdata;

   int mismatches;
   int bytes_pending;
   int bytes_checked;

   // flow control mix and stimulus bookkeeping
   int send_idle_pct = 34;
   int recv_idle_pct = 45;
   int n_items       = 0;
   int n_starts      = 0;
   int n_strays      = 0;
   int n_cuts        = 0;
   int n_settings    = 1;
   logic        tb_open = 1'b0;
   logic [15:0] tb_left = '0;

   udp_ipv6_frame_builder_core #(.RING_FRAMES(256)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   frame_byte_checker #(.RING_FRAMES(256)) scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .bytes_pending (bytes_pending),
      .bytes_checked (bytes_checked)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // receiver stalls
   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // present one item after random gaps, return once it is taken
   task automatic send_item(input logic starts, input logic [REQ_DATA_W-1:0] data);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= starts;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      n_items++;
   endtask

   task automatic send_start(input logic [15:0] len, input logic [63:0] dhi,
                             input logic [63:0] dlo, input logic [15:0] dport,
                             input logic [7:0] pbyte);
      if (tb_open) n_cuts++;
      n_starts++;
      send_item(1'b1, {pbyte, len, dport, dlo, dhi});
      tb_left = (len == 16'd0) ? 16'd0 : (len > MAX_PAYLOAD) ? MAX_PAYLOAD - 16'd1 : len - 16'd1;
      tb_open = (tb_left != 16'd0);
   endtask

   // header fields of a data item are don't-care, so they carry noise
   task automatic send_data(input logic [7:0] pbyte);
      if (!tb_open) begin
         n_strays++;
      end else begin
         tb_left = tb_left - 16'd1;
         tb_open = (tb_left != 16'd0);
      end
      send_item(1'b0, {pbyte, 16'($urandom), 16'($urandom), {$urandom, $urandom},
                       {$urandom, $urandom}});
   endtask

   task automatic send_rand_start(input logic [15:0] len);
      send_start(len, {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                 8'($urandom));
   endtask

   function automatic int pick_length();
      int p;
      p = $urandom_range(99);
      if (p < 60) return $urandom_range(1, 3);
      if (p < 90) return $urandom_range(4, 16);
      return $urandom_range(17, 80);
   endfunction

   // wait until every predicted byte has come out
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (bytes_pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [63:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // all registers to one fill value, or each to full-width noise
   task automatic load_regs(input bit noisy, input logic [63:0] fill);
      reg_index_type regs [7];
      regs = '{REG_SOURCE_MAC, REG_DEST_MAC, REG_SOURCE_IP_UPPER, REG_SOURCE_IP_LOWER,
               REG_SOURCE_PORT, REG_HOP_LIMIT, REG_CHECK_WORD};
      foreach (regs[i]) write_reg(regs[i], noisy ? {$urandom, $urandom} : fill);
      n_settings++;
   endtask

   // mostly whole packets; some abandoned ones, oversize lengths, zero lengths, strays
   task automatic random_traffic(input int count);
      int stop_at;
      int pick;
      int plen;
      stop_at = n_items + count;
      while (n_items < stop_at) begin
         pick = $urandom_range(99);
         plen = pick_length();
         if (pick < 6) begin
            send_data(8'($urandom));
         end else begin
            if (pick < 10) begin
               send_rand_start(16'($urandom_range(65528, 65535)));
               repeat ($urandom_range(0, 3)) send_data(8'($urandom));
            end else if (pick < 16) begin
               send_rand_start(16'(plen + 1));
               repeat ($urandom_range(0, plen - 1)) send_data(8'($urandom));
            end
            send_rand_start((pick < 19) ? 16'd0 : 16'(plen));
            while (tb_open) send_data(8'($urandom));
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = REG_SOURCE_MAC;
      csr_wdata  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at reset register values
      send_data(8'h00);                                        // stray byte at start
      send_start(16'd1, '1, '1, 16'hFFFF, 8'hFF);              // one-byte frame, all ones
      send_start(16'd0, '0, '0, 16'h0000, 8'h00);              // zero length, one byte
      send_start(16'd3, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 16'h8001, 8'h5A);
      send_data(8'hA5);
      send_data(8'h3C);
      send_start(16'hFFFF, '1, '0, 16'h7FFE, 8'h01);           // oversize length
      send_data(8'h80);
      send_start(16'd2, '0, '1, 16'h1234, 8'h7F);              // cuts the oversize one
      send_data(8'hFE);
      send_start(MAX_PAYLOAD, '1, '1, 16'hFFFF, 8'h11);        // largest length, then cut
      send_start(16'd1, '0, '0, 16'h0000, 8'h22);
      send_data(8'h81);                                        // stray after a frame
      send_start(16'd4, {$urandom, $urandom}, {$urandom, $urandom}, 16'h00FF, 8'h33);
      send_data(8'h44);
      send_start(16'd1, {$urandom, $urandom}, {$urandom, $urandom}, 16'hFF00, 8'h55);
      drain();

      // phase 1: sender and receiver both idling at random, registers all ones
      load_regs(1'b0, '1);
      random_traffic(110);
      drain();

      // phase 2: idle rates swapped, noisy register values
      send_idle_pct = 45;
      recv_idle_pct = 34;
      load_regs(1'b1, '0);
      random_traffic(110);
      drain();

      // phase 3: no idling, registers all zeros
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_regs(1'b0, '0);
      random_traffic(110);
      drain();

      // settle time before the verdict
      repeat (80) @(negedge clock);
      $display("Summary: %0d items in (%0d packet starts, %0d stray bytes, %0d cut short),",
               n_items, n_starts, n_strays, n_cuts);
      $display("Summary: %0d frame bytes checked over %0d register settings and 3 stall mixes",
               bytes_checked, n_settings);
      if (mismatches == 0 && bytes_pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
